>>> rtl/smm_pkg.sv
// Package with shared types and constants for the square matrix multiply core.
package smm_pkg;

    localparam int unsigned MaxDimLog2 = 3;
    localparam int unsigned IdxW       = 3;
    localparam int unsigned DataW      = 32;
    localparam int unsigned AddrW      = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_EMIT
    } exec_state_t;

    typedef struct packed {
        logic             which_matrix;
        logic [IdxW-1:0]  row;
        logic [IdxW-1:0]  col;
        logic [DataW-1:0] value;
        logic             go;
    } req_t;

endpackage

>>> rtl/smm_front.sv
// Front end: accept requests and hold them in a short queue for the executor.
module smm_front
    import smm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_req,
    output logic        q_valid,
    input  logic        q_ready,
    output req_t        q_req
);

    localparam int unsigned Depth = 2;

    req_t       fifo_reg [Depth];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = fifo_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= in_req;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("queue count did not advance");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (wptr_reg == rptr_reg))
        else $error("queue pointers out of step when empty");

endmodule

>>> rtl/smm_exec.sv
// Executor: write the A and B stores and run the multiply-accumulate sweep.
module smm_exec
    import smm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        size_log2,
    input  logic              q_valid,
    output logic              q_ready,
    input  req_t              q_req,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IdxW-1:0]   out_row,
    output logic [IdxW-1:0]   out_col,
    output logic [DataW-1:0]  out_product,
    output logic              out_last
);

    localparam int unsigned Entries = 1 << AddrW;

    logic [DataW-1:0] mem_a [Entries];
    logic [DataW-1:0] mem_b [Entries];
    logic [Entries-1:0] vld_a_reg, vld_b_reg;

    exec_state_t state_reg, state_next;
    logic [IdxW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IdxW-1:0] last_idx_reg, last_idx_next;
    logic [DataW-1:0] acc_reg, acc_next;
    logic [DataW-1:0] rd_a_reg, rd_b_reg;
    logic rd_va_reg, rd_vb_reg;
    logic [DataW-1:0] prod_reg;
    logic prod_valid_reg, prod_valid_next;
    logic rd_valid_reg, rd_valid_next;
    logic ov_reg, ov_next;
    logic [IdxW-1:0] or_reg, oc_reg;
    logic [DataW-1:0] op_reg;
    logic ol_reg;
    logic wr_en, take, rd_en, last_k;
    logic [AddrW-1:0] a_addr, b_addr, w_addr;
    logic [2*IdxW+DataW+1-1:0] out_pack_next;

    assign w_addr  = {q_req.row, q_req.col};
    assign a_addr  = {i_reg, k_reg};
    assign b_addr  = {k_reg, j_reg};
    assign q_ready = (state_reg == ST_IDLE);
    assign take    = q_valid && q_ready;
    assign wr_en   = take;
    assign last_k  = (k_reg == last_idx_reg);

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        last_idx_next   = last_idx_reg;
        rd_en           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && q_req.go)
                begin
                    state_next    = ST_READ;
                    i_next        = '0;
                    j_next        = '0;
                    k_next        = '0;
                    last_idx_next = IdxW'((1 << size_log2) - 1);
                end
            end
            ST_READ:
            begin
                rd_en           = 1'b1;
                if (last_k)
                begin
                    k_next     = '0;
                    state_next = ST_MAC;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_MAC:
            begin
                if (!rd_valid_reg && !prod_valid_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    if (j_reg == last_idx_reg)
                    begin
                        j_next = '0;
                        if (i_reg == last_idx_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_valid_next   = rd_en;
        prod_valid_next = rd_valid_reg;
        acc_next        = acc_reg;
        if (state_reg == ST_READ && k_reg == '0)
        begin
            acc_next = '0;
        end
        if (prod_valid_reg)
        begin
            acc_next = acc_next + prod_reg;
        end
        ov_next = ov_reg;
        if (out_ready)
        begin
            ov_next = 1'b0;
        end
        if (state_reg == ST_EMIT && (!ov_reg || out_ready))
        begin
            ov_next = 1'b1;
        end
        out_pack_next = {i_reg, j_reg, acc_reg,
            (i_reg == last_idx_reg) && (j_reg == last_idx_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            vld_a_reg      <= '0;
            vld_b_reg      <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_valid_reg   <= rd_valid_next;
            prod_valid_reg <= prod_valid_next;
            ov_reg         <= ov_next;
            if (wr_en && !q_req.which_matrix)
            begin
                vld_a_reg[w_addr] <= 1'b1;
            end
            if (wr_en && q_req.which_matrix)
            begin
                vld_b_reg[w_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        k_reg          <= k_next;
        last_idx_reg   <= last_idx_next;
        acc_reg        <= acc_next;
        if (wr_en && !q_req.which_matrix)
        begin
            mem_a[w_addr] <= q_req.value;
        end
        if (wr_en && q_req.which_matrix)
        begin
            mem_b[w_addr] <= q_req.value;
        end
        rd_a_reg  <= mem_a[a_addr];
        rd_b_reg  <= mem_b[b_addr];
        rd_va_reg <= vld_a_reg[a_addr];
        rd_vb_reg <= vld_b_reg[b_addr];
        prod_reg  <= (rd_va_reg ? rd_a_reg : '0) * (rd_vb_reg ? rd_b_reg : '0);
        if (state_reg == ST_EMIT && (!ov_reg || out_ready))
        begin
            {or_reg, oc_reg, op_reg, ol_reg} <= out_pack_next;
        end
    end

    assign out_valid   = ov_reg;
    assign out_row     = or_reg;
    assign out_col     = oc_reg;
    assign out_product = op_reg;
    assign out_last    = ol_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !q_ready)
        else $error("queue drained during sweep");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (!rd_valid_reg && !prod_valid_reg))
        else $error("emit with products in flight");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg)
        else $error("result dropped while stalled");

endmodule

>>> rtl/square_matrix_multiply_core.sv
// Top level of the square matrix multiply core.
// Load requests pass through a two-entry queue.
// A go request then runs one multiply-accumulate per cycle through the store read
// ports, plus pipeline drain per product element, and stalls while the output is held.
// Results leave through a registered output stage.
// rst_n clears control state, valid bits of both stores and size_log2 to 3.
module square_matrix_multiply_core
    import smm_pkg::*;
#(
    parameter int unsigned MAX_DIM = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,    // size_log2[1:0], zero fill
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,     // row[2:0], col[5:3], value[37:6], zero fill
    input  logic [1:0]  s_tuser,     // which_matrix[0], go[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // out_row[2:0], out_col[5:3], product[37:6], zero fill
    output logic        m_tlast
);

    logic [1:0]  size_log2_reg;
    logic [1:0]  size_eff;
    req_t        in_req, q_req;
    logic        q_valid, q_ready;
    logic [IdxW-1:0]  o_row, o_col;
    logic [DataW-1:0] o_prod;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= 2'd3;
        end
        else if (cfg_valid)
        begin
            size_log2_reg <= cfg_data[1:0];
        end
    end

    assign size_eff = (32'(1) << size_log2_reg) > MAX_DIM ? 2'($clog2(MAX_DIM))
                                                          : size_log2_reg;

    always_comb
    begin
        in_req.which_matrix = s_tuser[0];
        in_req.row          = s_tdata[2:0];
        in_req.col          = s_tdata[5:3];
        in_req.value        = s_tdata[37:6];
        in_req.go           = s_tuser[1];
    end

    smm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    smm_exec u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .size_log2   (size_eff),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_req       (q_req),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_row     (o_row),
        .out_col     (o_col),
        .out_product (o_prod),
        .out_last    (m_tlast)
    );

    assign m_tdata = {2'b00, o_prod, o_col, o_row};

endmodule
